FILE: design/cab_pkg.sv
// Shared types and constants for the conditional alert blinker.
// No dependencies; every other file imports this package.
package cab_pkg;

   // Field widths.
   localparam int TIME_W  = 32;
   localparam int COLOR_W = 24;
   localparam int COUNT_W = 4;
   localparam int COND_W  = 8;

   // Number of condition sources that can take part in arming.
   localparam int MAX_CONDITIONS = 8;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_W-1:0] REG_BLINK_INTERVAL  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ALERT_COLOR     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CONDITION_COUNT = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_INVERT_MASK     = 2'd3;

   // Register reset values.
   localparam logic [TIME_W-1:0]  BLINK_INTERVAL_RST  = 32'd500;
   localparam logic [COLOR_W-1:0] ALERT_COLOR_RST     = 24'hFF0000;
   localparam logic [COUNT_W-1:0] CONDITION_COUNT_RST = 4'd0;
   localparam logic [COND_W-1:0]  INVERT_MASK_RST     = 8'd0;

   // Serial divider step counter width.
   localparam int DIV_CNT_W = $clog2(TIME_W);

   // Configuration seen by the blink controller.
   typedef struct packed {
      logic [TIME_W-1:0]  blink_interval;
      logic [COLOR_W-1:0] alert_color;
      logic [COUNT_W-1:0] condition_count;
      logic [COND_W-1:0]  invert_mask;
   } cfg_type;

endpackage

FILE: design/cab_req_if.sv
// Tick channel: valid/ready handshake with timestamp and condition bits.
// Depends on cab_pkg for the field widths.
interface cab_req_if import cab_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] tick_time;
   logic [COND_W-1:0] condition_bits;

   modport source (output valid, tick_time, condition_bits, input ready);
   modport sink (input valid, tick_time, condition_bits, output ready);
endinterface

FILE: design/cab_rsp_if.sv
// Paint channel: valid/ready handshake with fill color and show timestamp.
// Depends on cab_pkg for the field widths.
interface cab_rsp_if import cab_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] paint_color;
   logic [TIME_W-1:0]  show_time;

   modport source (output valid, paint_color, show_time, input ready);
   modport sink (input valid, paint_color, show_time, output ready);
endinterface

FILE: design/conditional_alert_blinker.sv
// Conditional alert blinker. Each accepted tick is checked against the configured
// conditions; the block paints black once when disarmed, paints the alert color
// at once on arming, and while armed toggles the color each odd number of whole
// blink intervals elapsed. While the alert stays armed with a nonzero interval, the
// elapsed time is split by the 32-step bit-serial divider, and the controller waits
// in its divide state until the divider is done. A result sits in an output register,
// so the next tick is taken while it waits; a further result is held until that
// register frees.
module conditional_alert_blinker import cab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cab_req_if.sink               req_chan,
   cab_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   cfg_type                   cfg;
   logic [1:0]                state_ff, state_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic [COND_W-1:0]         bits_ff, bits_in;
   logic                      has_painted_ff, has_painted_in;
   logic                      was_armed_ff, was_armed_in;
   logic                      lit_phase_ff, lit_phase_in;
   logic [TIME_W-1:0]         last_toggle_ff, last_toggle_in;
   logic [COLOR_W-1:0]        pend_color_ff, pend_color_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]        rsp_color_ff, rsp_color_in;
   logic [TIME_W-1:0]         rsp_time_ff, rsp_time_in;
   logic                      in_xfer;
   logic                      out_load;
   logic                      armed;
   logic [COUNT_W-1:0]        cond_used;
   logic [MAX_CONDITIONS-1:0] cond_met;
   logic                      div_start;
   logic                      div_done;
   logic                      div_odd;
   logic [TIME_W-1:0]         div_rem;
   logic [TIME_W-1:0]         elapsed;

   cab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign elapsed = now_ff - last_toggle_ff;

   cab_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend     (elapsed),
      .divisor      (cfg.blink_interval),
      .done         (div_done),
      .quotient_odd (div_odd),
      .remainder    (div_rem)
   );

   // Arming check: every condition in use must differ from its invert bit.
   // A condition without an input bit reads as inactive and not inverted, so it is unmet.
   always_comb begin
      cond_met  = MAX_CONDITIONS'(bits_ff ^ cfg.invert_mask);
      cond_used = (int'(cfg.condition_count) > MAX_CONDITIONS) ?
                  COUNT_W'(MAX_CONDITIONS) : cfg.condition_count;
      armed = (cond_used != '0);
      for (int i = 0; i < MAX_CONDITIONS; i++) begin
         if ((i < int'(cond_used)) && !cond_met[i]) begin
            armed = 1'b0;
         end
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign in_xfer        = req_chan.valid & req_chan.ready;
   assign out_load       = (state_ff == S_EMIT) & (~rsp_valid_ff | rsp_chan.ready);

   // Blink controller.
   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      bits_in        = bits_ff;
      has_painted_in = has_painted_ff;
      was_armed_in   = was_armed_ff;
      lit_phase_in   = lit_phase_ff;
      last_toggle_in = last_toggle_ff;
      pend_color_in  = pend_color_ff;
      div_start      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               now_in   = req_chan.tick_time;
               bits_in  = req_chan.condition_bits;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!armed) begin
               was_armed_in = 1'b0;
               if (!has_painted_ff || was_armed_ff || lit_phase_ff) begin
                  lit_phase_in   = 1'b0;
                  has_painted_in = 1'b1;
                  last_toggle_in = now_ff;
                  pend_color_in  = '0;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (!has_painted_ff || !was_armed_ff) begin
               lit_phase_in   = 1'b1;
               has_painted_in = 1'b1;
               was_armed_in   = 1'b1;
               last_toggle_in = now_ff;
               pend_color_in  = cfg.alert_color;
               state_in       = S_EMIT;
            end else if (cfg.blink_interval == '0) begin
               state_in = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               // Advancing by whole intervals leaves the clock at now minus the remainder.
               last_toggle_in = now_ff - div_rem;
               if (div_odd) begin
                  lit_phase_in  = ~lit_phase_ff;
                  pend_color_in = lit_phase_ff ? '0 : cfg.alert_color;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: holds a result until its transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_time_in  = rsp_time_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = pend_color_ff;
         rsp_time_in  = now_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         has_painted_ff <= 1'b0;
         was_armed_ff   <= 1'b0;
         lit_phase_ff   <= 1'b0;
         last_toggle_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         has_painted_ff <= has_painted_in;
         was_armed_ff   <= was_armed_in;
         lit_phase_ff   <= lit_phase_in;
         last_toggle_ff <= last_toggle_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      bits_ff       <= bits_in;
      pend_color_ff <= pend_color_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_time_ff   <= rsp_time_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.paint_color = rsp_color_ff;
   assign rsp_chan.show_time   = rsp_time_ff;

endmodule

FILE: design/cab_csr.sv
// APB-style register file holding the blinker configuration.
// Depends on cab_pkg for widths, register indexes and reset values.
module cab_csr import cab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff, cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign cfg     = cfg_ff;

   // Register write decode; each register takes its low bits of the data.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BLINK_INTERVAL:  cfg_in.blink_interval  = pwdata[TIME_W-1:0];
            REG_ALERT_COLOR:     cfg_in.alert_color     = pwdata[COLOR_W-1:0];
            REG_CONDITION_COUNT: cfg_in.condition_count = pwdata[COUNT_W-1:0];
            REG_INVERT_MASK:     cfg_in.invert_mask     = pwdata[COND_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_interval  <= BLINK_INTERVAL_RST;
         cfg_ff.alert_color     <= ALERT_COLOR_RST;
         cfg_ff.condition_count <= CONDITION_COUNT_RST;
         cfg_ff.invert_mask     <= INVERT_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux, zero-extended to the bus width.
   always_comb begin
      unique case (reg_idx)
         REG_BLINK_INTERVAL:  prdata = CSR_DATA_W'(cfg_ff.blink_interval);
         REG_ALERT_COLOR:     prdata = CSR_DATA_W'(cfg_ff.alert_color);
         REG_CONDITION_COUNT: prdata = CSR_DATA_W'(cfg_ff.condition_count);
         REG_INVERT_MASK:     prdata = CSR_DATA_W'(cfg_ff.invert_mask);
         default:             prdata = '0;
      endcase
   end

endmodule

FILE: design/cab_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on cab_pkg for the operand width and step counter width.
module cab_divider import cab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic              quotient_odd,
   output logic [TIME_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]    dvd_ff, dvd_in;
   logic [TIME_W-1:0]    dsr_ff, dsr_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 qbit;

   // One restoring step: bring in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, dvd_ff[TIME_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      qbit  = ~diff[TIME_W];
   end

   // The dividend register shifts left; quotient bits fill in from the bottom.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[TIME_W-2:0], qbit};
         rem_in   = qbit ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done         = done_ff;
   assign quotient_odd = dvd_ff[0];
   assign remainder    = rem_ff;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for conditional_alert_blinker: directed table, then random phases.
// Depends on cab_pkg and the cab_req_if / cab_rsp_if interfaces from the design folder.
module tb_top;
   import cab_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {ROW_TICK, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {EXP_MODEL, EXP_PAINT, EXP_QUIET} check_type;

   // One directed step: either a tick or a register write.
   typedef struct packed {
      row_kind_type           kind;
      logic [REG_IDX_W-1:0]   idx;
      logic [TIME_W-1:0]      value;
      logic [COND_W-1:0]      bits;
      check_type              chk;
      logic [COLOR_W-1:0]     color;
   } stim_row_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [TIME_W-1:0]  stamp;
   } paint_type;

   localparam int NUM_DIRECTED = 37;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cab_req_if req_if ();
   cab_rsp_if rsp_if ();

   conditional_alert_blinker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies and blink state of the predictor.
   logic [TIME_W-1:0]  interval_ms;
   logic [COLOR_W-1:0] alert_rgb;
   logic [COUNT_W-1:0] cond_count;
   logic [COND_W-1:0]  cond_invert;
   bit                 strip_painted;
   bit                 armed_before;
   bit                 lit_on;
   logic [TIME_W-1:0]  toggle_mark;

   paint_type expected_paints [$];
   int        mismatches   = 0;
   int        stall_cycles = 0;
   int        req_calm     = 0;
   int        rsp_calm     = 0;

   // Directed steps: reset state, blink timing, wrap, count clamping, zero and maximum interval.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_TICK, '0, 32'd100, 8'h00, EXP_PAINT, 24'h000000},
      '{ROW_TICK, '0, 32'd200, 8'hFF, EXP_QUIET, 24'h000000},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd1, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd300, 8'h01, EXP_PAINT, 24'hFF0000},
      '{ROW_TICK, '0, 32'd799, 8'h01, EXP_QUIET, 24'h000000},
      '{ROW_TICK, '0, 32'd800, 8'h01, EXP_PAINT, 24'h000000},
      '{ROW_TICK, '0, 32'd1800, 8'h01, EXP_QUIET, 24'h000000},
      '{ROW_TICK, '0, 32'd2300, 8'h01, EXP_PAINT, 24'hFF0000},
      '{ROW_TICK, '0, 32'd2400, 8'h00, EXP_PAINT, 24'h000000},
      '{ROW_TICK, '0, 32'd2500, 8'h00, EXP_QUIET, 24'h000000},
      '{ROW_CFG, REG_ALERT_COLOR, 32'h00FF_FFFF, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_INVERT_MASK, 32'h0000_00FF, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd8, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'hFFFF_FFF0, 8'h00, EXP_PAINT, 24'hFFFFFF},
      '{ROW_TICK, '0, 32'h0000_01E4, 8'h00, EXP_PAINT, 24'h000000},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd15, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'h0000_03D8, 8'h00, EXP_PAINT, 24'hFFFFFF},
      '{ROW_TICK, '0, 32'h0000_03D9, 8'h7F, EXP_PAINT, 24'h000000},
      '{ROW_CFG, REG_BLINK_INTERVAL, 32'd0, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_INVERT_MASK, 32'd0, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd8, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_ALERT_COLOR, 32'h0012_3456, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd5, 8'hFF, EXP_PAINT, 24'h123456},
      '{ROW_TICK, '0, 32'hFFFF_FFFF, 8'hFF, EXP_QUIET, 24'h000000},
      '{ROW_TICK, '0, 32'd77, 8'hFF, EXP_QUIET, 24'h000000},
      '{ROW_CFG, REG_BLINK_INTERVAL, 32'hFFFF_FFFF, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd0, 8'hFF, EXP_QUIET, 24'h000000},
      '{ROW_TICK, '0, 32'd4, 8'hFF, EXP_PAINT, 24'h000000},
      '{ROW_CFG, REG_BLINK_INTERVAL, 32'd1, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd7, 8'hFF, EXP_MODEL, 24'h000000},
      '{ROW_TICK, '0, 32'd9, 8'hFF, EXP_MODEL, 24'h000000},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd0, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd10, 8'hFF, EXP_PAINT, 24'h000000},
      '{ROW_CFG, REG_CONDITION_COUNT, 32'd3, '0, EXP_MODEL, '0},
      '{ROW_CFG, REG_INVERT_MASK, 32'h0000_0005, '0, EXP_MODEL, '0},
      '{ROW_TICK, '0, 32'd11, 8'hFA, EXP_MODEL, 24'h000000},
      '{ROW_TICK, '0, 32'd12, 8'hFB, EXP_MODEL, 24'h000000}
   };

   // Works out the paint, if any, caused by one tick and advances the blink state.
   function automatic bit next_paint(input logic [TIME_W-1:0] now,
                                     input logic [COND_W-1:0] bits,
                                     output logic [COLOR_W-1:0] color);
      int                n;
      bit                armed;
      bit                hit;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] intervals;
      color = '0;
      n = (cond_count > MAX_CONDITIONS) ? MAX_CONDITIONS : int'(cond_count);
      armed = (n != 0);
      // A condition without an input bit is never met.
      for (int i = 0; i < n; i++) begin
         if (i >= COND_W || bits[i] == cond_invert[i]) armed = 1'b0;
      end

      // Disarmed: black once, and again whenever the strip may still be lit.
      if (!armed) begin
         hit = !strip_painted || armed_before || lit_on;
         armed_before = 1'b0;
         if (hit) begin
            lit_on = 1'b0;
            strip_painted = 1'b1;
            toggle_mark = now;
         end
         return hit;
      end

      // Freshly armed: paint the alert color and restart the blink clock.
      if (!strip_painted || !armed_before) begin
         lit_on = 1'b1;
         toggle_mark = now;
         strip_painted = 1'b1;
         armed_before = 1'b1;
         color = alert_rgb;
         return 1'b1;
      end

      // Still armed: advance by whole intervals, toggle on an odd count.
      if (interval_ms == '0) return 1'b0;
      elapsed = now - toggle_mark;
      if (elapsed < interval_ms) return 1'b0;
      intervals = elapsed / interval_ms;
      toggle_mark = toggle_mark + intervals * interval_ms;
      if (!intervals[0]) return 1'b0;
      lit_on = !lit_on;
      color = lit_on ? alert_rgb : '0;
      return 1'b1;
   endfunction

   // Number of idle cycles before the next transfer; sometimes starts a run with no idling.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, what);
   endfunction

   // Sends one tick and records what it should paint once the transfer happens.
   task automatic send_tick(input logic [TIME_W-1:0] t, input logic [COND_W-1:0] bits,
                            input check_type chk, input logic [COLOR_W-1:0] typed_color);
      int                 gap;
      bit                 hit;
      logic [COLOR_W-1:0] color;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.tick_time      <= t;
      req_if.condition_bits <= bits;
      do @(posedge clock); while (!req_if.ready);
      hit = next_paint(t, bits, color);
      case (chk)
         EXP_MODEL: if (hit) expected_paints.push_back(paint_type'{color, t});
         EXP_PAINT: expected_paints.push_back(paint_type'{typed_color, t});
         default: ;
      endcase
   endtask

   // Two-phase register write, then idles with psel low so the next write starts cleanly.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_BLINK_INTERVAL:  interval_ms = value;
         REG_ALERT_COLOR:     alert_rgb   = value[COLOR_W-1:0];
         REG_CONDITION_COUNT: cond_count  = value[COUNT_W-1:0];
         REG_INVERT_MASK:     cond_invert = value[COND_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stops ticks, waits for every expected paint, then lets a tick still in the divider finish.
   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      while (expected_paints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main stimulus: reset, directed table, then random configuration phases.
   initial begin
      int                 p;
      int                 n;
      int                 items_sent;
      int                 eff;
      int                 streak;
      bit                 want_armed;
      logic [TIME_W-1:0]  t_now;
      logic [TIME_W-1:0]  delta;
      logic [COND_W-1:0]  bits;
      logic [COND_W-1:0]  fill;
      logic [COND_W-1:0]  low_mask;
      logic [TIME_W-1:0]  iv;
      logic [COLOR_W-1:0] col;
      logic [COUNT_W-1:0] cnt;
      logic [COND_W-1:0]  inv;

      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.tick_time      <= '0;
      req_if.condition_bits <= '0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;

      interval_ms   = BLINK_INTERVAL_RST;
      alert_rgb     = ALERT_COLOR_RST;
      cond_count    = CONDITION_COUNT_RST;
      cond_invert   = INVERT_MASK_RST;
      strip_painted = 1'b0;
      armed_before  = 1'b0;
      lit_on        = 1'b0;
      toggle_mark   = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            drain_and_settle();
            csr_write(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_tick(directed_rows[i].value, directed_rows[i].bits,
                      directed_rows[i].chk, directed_rows[i].color);
         end
      end

      // Random part: each phase sets all registers, then runs a stream of ticks.
      items_sent = 0;
      streak     = 0;
      want_armed = 1'b1;
      t_now      = $urandom();
      p          = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (p)
            0: begin iv = 32'd1; col = 24'hFFFFFF; cnt = 4'd8; inv = 8'hFF; end
            1: begin iv = 32'hFFFF_FFFF; col = 24'h000000; cnt = 4'd0; inv = 8'h00; end
            2: begin iv = 32'd0; col = 24'($urandom()); cnt = 4'd15; inv = 8'($urandom()); end
            3: begin iv = 32'd500; col = 24'hFF0000; cnt = 4'd1; inv = 8'h00; end
            default: begin
               case ($urandom_range(0, 9))
                  0: iv = 32'd0;
                  1: iv = 32'd1;
                  2: iv = $urandom();
                  3: iv = 32'hFFFF_FFFF;
                  4, 5: iv = $urandom_range(1, 20);
                  default: iv = $urandom_range(20, 2000);
               endcase
               col = 24'($urandom());
               cnt = $urandom_range(0, 3) != 0 ? 4'($urandom_range(1, 8))
                                               : 4'($urandom_range(0, 15));
               inv = 8'($urandom());
            end
         endcase
         drain_and_settle();
         csr_write(REG_BLINK_INTERVAL, iv);
         csr_write(REG_ALERT_COLOR, {8'h00, col});
         csr_write(REG_CONDITION_COUNT, {28'h0, cnt});
         csr_write(REG_INVERT_MASK, {24'h0, inv});

         eff      = (cond_count > MAX_CONDITIONS) ? MAX_CONDITIONS : int'(cond_count);
         low_mask = 8'((1 << eff) - 1);
         n        = $urandom_range(60, 200);
         for (int k = 0; k < n; k++) begin
            // Time moves mostly in steps on the scale of the interval, with rare jumps.
            case ($urandom_range(0, 19))
               0: delta = $urandom();
               1: delta = '0;
               default: begin
                  if (interval_ms == '0 || interval_ms > 32'h1000_0000)
                     delta = interval_ms * $urandom_range(0, 2) + $urandom_range(0, 2) - 1;
                  else
                     delta = $urandom_range(0, 3 * interval_ms);
               end
            endcase
            t_now = t_now + delta;

            // Conditions hold armed or disarmed for short streaks.
            if (streak == 0) begin
               streak     = $urandom_range(1, 12);
               want_armed = $urandom_range(0, 3) != 0;
            end
            streak--;
            fill = 8'($urandom());
            bits = (~cond_invert & low_mask) | (fill & ~low_mask);
            if ($urandom_range(0, 15) == 0) begin
               bits = fill;
            end else if (!want_armed) begin
               bits = bits ^ (8'd1 << $urandom_range(0, (eff == 0) ? 0 : eff - 1));
            end
            send_tick(t_now, bits, EXP_MODEL, '0);
            items_sent++;
         end
         p++;
      end

      drain_and_settle();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Result side: random stalls on ready, each transfer checked against the oldest expectation.
   initial begin
      int        stall;
      paint_type want;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (expected_paints.size() == 0) begin
            note_mismatch($sformatf("paint with nothing expected: color %06h show_time %08h",
                                    rsp_if.paint_color, rsp_if.show_time));
         end else begin
            want = expected_paints.pop_front();
            if (rsp_if.paint_color !== want.color)
               note_mismatch($sformatf("paint_color expected %06h got %06h (tick %08h)",
                                       want.color, rsp_if.paint_color, want.stamp));
            if (rsp_if.show_time !== want.stamp)
               note_mismatch($sformatf("show_time expected %08h got %08h",
                                       want.stamp, rsp_if.show_time));
         end
      end
   end

   // Watchdog: ends the run when no transfer or register write happens for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
